/* hw/rtl/sjc_pkg.sv */
// shared types, constants and arithmetic helpers for skeletal joint composition
package sjc_pkg;

   localparam int MaxBones = 256;
   localparam int SlotW = $clog2(MaxBones);
   localparam logic [15:0] RootMark = 16'hFFFF;

   // opcodes for the shared multiply-accumulate datapath
   typedef enum logic [3:0] {
      OP_SCL   = 4'd0,
      OP_QUAT  = 4'd1,
      OP_MAT   = 4'd2,
      OP_SVEC  = 4'd3,
      OP_ROT   = 4'd4,
      OP_NONE  = 4'd5
   } op_type;

   typedef struct packed {
      logic       load;
      logic       rd_parent;
      logic       wr_joint;
      op_type     op;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic is_root;
      logic fault;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
      if (x > 67'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -67'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // floor(x / 2^s + 1/2)
   function automatic logic signed [66:0] rnd(input logic signed [66:0] x, input int s);
      logic signed [66:0] h;
      h = 67'sd1 <<< (s - 1);
      return (x + h) >>> s;
   endfunction

endpackage

/* hw/rtl/sjc_ram.sv */
// generic single-port ram with registered read
module sjc_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

/* hw/rtl/sjc_ctrl.sv */
// sequencer for one bone: load, parent read, compose steps (skipped for a root or faulty parent), store, hand off
module sjc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sjc_pkg::sts_type sts,
   output sjc_pkg::cmd_type cmd
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_WAIT = 6'b000100,
      S_CALC = 6'b001000,
      S_STORE = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '{load: 1'b0, rd_parent: 1'b0, wr_joint: 1'b0, op: sjc_pkg::OP_NONE, idx: 4'd0};
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_parent = 1'b1;
            state_in = (sts.is_root || sts.fault) ? S_STORE : S_WAIT;
            step_in = 5'd0;
         end
         S_WAIT: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            // 3 scale, 4 quat, 9 matrix, 3 scaled vector, 3 rotated
            if (step_ff < 5'd3) begin
               cmd.op = sjc_pkg::OP_SCL; cmd.idx = step_ff[3:0];
            end else if (step_ff < 5'd7) begin
               cmd.op = sjc_pkg::OP_QUAT; cmd.idx = 4'(step_ff - 5'd3);
            end else if (step_ff < 5'd16) begin
               cmd.op = sjc_pkg::OP_MAT; cmd.idx = 4'(step_ff - 5'd7);
            end else if (step_ff < 5'd19) begin
               cmd.op = sjc_pkg::OP_SVEC; cmd.idx = 4'(step_ff - 5'd16);
            end else begin
               cmd.op = sjc_pkg::OP_ROT; cmd.idx = 4'(step_ff - 5'd19);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd21) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.wr_joint = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_load_to_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_READ) else $error("load lost");
   a_store_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_joint |=> rsp_valid) else $error("store without result");
`endif
endmodule

/* hw/rtl/sjc_datapath.sv */
// joint registers, store memory and one shared multiply-round unit
module sjc_datapath (
   input  logic                clock,
   input  sjc_pkg::cmd_type    cmd,
   output sjc_pkg::sts_type    sts,
   input  logic [7:0]          req_bone_slot,
   input  logic [15:0]         req_parent_slot,
   input  logic signed [31:0]  req_pos [3],
   input  logic signed [31:0]  req_rot [4],
   input  logic signed [31:0]  req_scl [3],
   output logic [7:0]          rsp_bone_slot,
   output logic signed [31:0]  rsp_pos [3],
   output logic signed [31:0]  rsp_rot [4],
   output logic signed [31:0]  rsp_scl [3],
   output logic                rsp_fault
);
   localparam int JW = 320;

   logic [7:0]         bone_ff;
   logic [15:0]        par_ff;
   logic signed [31:0] cp_ff [3], cq_ff [4], cs_ff [3];
   logic signed [31:0] rp_ff [3], rq_ff [4], rs_ff [3];
   logic signed [31:0] m_ff [9], sv_ff [3];
   logic               root_ff, fault_ff;
   logic [JW-1:0]      rdata, wdata;
   logic signed [31:0] pp [3], pq [4], ps [3];
   logic [sjc_pkg::SlotW-1:0] addr;
   logic               bone_ok;

   // whole joint lives in one wide word per slot
   assign bone_ok = 9'(bone_ff) < 9'(sjc_pkg::MaxBones);
   assign addr = cmd.wr_joint ? bone_ff[sjc_pkg::SlotW-1:0] : par_ff[sjc_pkg::SlotW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pp[i] = rdata[32*i +: 32];
         ps[i] = rdata[32*(7+i) +: 32];
         wdata[32*i +: 32] = rp_ff[i];
         wdata[32*(7+i) +: 32] = rs_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         pq[i] = rdata[32*(3+i) +: 32];
         wdata[32*(3+i) +: 32] = rq_ff[i];
      end
   end

   sjc_ram #(.Width(JW), .Depth(sjc_pkg::MaxBones)) u_store (
      .clock(clock), .we(cmd.wr_joint && bone_ok), .addr(addr),
      .wdata(wdata), .rdata(rdata));

   assign sts.is_root = (par_ff == sjc_pkg::RootMark);
   assign sts.fault = !sts.is_root && ((par_ff >= 16'(bone_ff))
                      || (17'(par_ff) >= 17'(sjc_pkg::MaxBones)));

   // operand selection: up to four signed products per step
   logic signed [31:0] a [4], b [4];
   logic signed [1:0]  sg [4];
   logic signed [63:0] pr [4];
   logic signed [66:0] acc;
   logic signed [31:0] res;
   logic [3:0] k;
   logic signed [31:0] x, y, z, w;

   assign x = pq[0]; assign y = pq[1]; assign z = pq[2]; assign w = pq[3];
   assign k = cmd.idx;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a[i] = '0; b[i] = '0; sg[i] = 2'sd0;
      end
      case (cmd.op)
         sjc_pkg::OP_SCL, sjc_pkg::OP_SVEC: begin
            a[0] = ps[k[1:0]];
            b[0] = (cmd.op == sjc_pkg::OP_SCL) ? cs_ff[k[1:0]] : cp_ff[k[1:0]];
            sg[0] = 2'sd1;
         end
         sjc_pkg::OP_QUAT: begin
            for (int i = 0; i < 4; i++) sg[i] = 2'sd1;
            case (k[1:0])
               2'd0: begin
                  a = '{w, x, y, z}; b = '{cq_ff[0], cq_ff[3], cq_ff[2], cq_ff[1]};
                  sg[3] = -2'sd1;
               end
               2'd1: begin
                  a = '{w, x, y, z}; b = '{cq_ff[1], cq_ff[2], cq_ff[3], cq_ff[0]};
                  sg[1] = -2'sd1;
               end
               2'd2: begin
                  a = '{w, x, y, z}; b = '{cq_ff[2], cq_ff[1], cq_ff[0], cq_ff[3]};
                  sg[2] = -2'sd1;
               end
               default: begin
                  a = '{w, x, y, z}; b = '{cq_ff[3], cq_ff[0], cq_ff[1], cq_ff[2]};
                  sg[1] = -2'sd1; sg[2] = -2'sd1; sg[3] = -2'sd1;
               end
            endcase
         end
         sjc_pkg::OP_MAT: begin
            sg[0] = 2'sd1; sg[1] = 2'sd1;
            case (k)
               4'd0: begin a[0] = y; b[0] = y; a[1] = z; b[1] = z; sg = '{-2'sd1, -2'sd1, 2'sd0, 2'sd0}; end
               4'd1: begin a[0] = x; b[0] = y; a[1] = w; b[1] = z; sg[1] = -2'sd1; end
               4'd2: begin a[0] = x; b[0] = z; a[1] = w; b[1] = y; end
               4'd3: begin a[0] = x; b[0] = y; a[1] = w; b[1] = z; end
               4'd4: begin a[0] = x; b[0] = x; a[1] = z; b[1] = z; sg = '{-2'sd1, -2'sd1, 2'sd0, 2'sd0}; end
               4'd5: begin a[0] = y; b[0] = z; a[1] = w; b[1] = x; sg[1] = -2'sd1; end
               4'd6: begin a[0] = x; b[0] = z; a[1] = w; b[1] = y; sg[1] = -2'sd1; end
               4'd7: begin a[0] = y; b[0] = z; a[1] = w; b[1] = x; end
               default: begin a[0] = x; b[0] = x; a[1] = y; b[1] = y; sg = '{-2'sd1, -2'sd1, 2'sd0, 2'sd0}; end
            endcase
         end
         sjc_pkg::OP_ROT: begin
            for (int i = 0; i < 3; i++) begin
               a[i] = m_ff[3*k[1:0] + i]; b[i] = sv_ff[i]; sg[i] = 2'sd1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         pr[i] = a[i] * b[i];
         if (sg[i] == 2'sd1) acc = acc + 67'(pr[i]);
         else if (sg[i] == -2'sd1) acc = acc - 67'(pr[i]);
      end
      case (cmd.op)
         sjc_pkg::OP_SCL, sjc_pkg::OP_SVEC: res = sjc_pkg::sat32(sjc_pkg::rnd(acc, 16));
         sjc_pkg::OP_QUAT: res = sjc_pkg::sat32(sjc_pkg::rnd(acc, 30));
         sjc_pkg::OP_MAT: begin
            if (k == 4'd0 || k == 4'd4 || k == 4'd8)
               res = sjc_pkg::sat32(sjc_pkg::rnd(acc, 29) + 67'sd1073741824);
            else
               res = sjc_pkg::sat32(sjc_pkg::rnd(acc, 29));
         end
         sjc_pkg::OP_ROT: res = sjc_pkg::sat32(sjc_pkg::rnd(acc, 30) + 67'(pp[k[1:0]]));
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bone_ff <= req_bone_slot;
         par_ff <= req_parent_slot;
         cp_ff <= req_pos; cq_ff <= req_rot; cs_ff <= req_scl;
         rp_ff <= req_pos; rq_ff <= req_rot; rs_ff <= req_scl;
      end
      if (cmd.rd_parent) begin
         root_ff <= sts.is_root;
         fault_ff <= sts.fault;
      end
      case (cmd.op)
         sjc_pkg::OP_SCL: rs_ff[k[1:0]] <= res;
         sjc_pkg::OP_QUAT: rq_ff[k[1:0]] <= res;
         sjc_pkg::OP_MAT: m_ff[k] <= res;
         sjc_pkg::OP_SVEC: sv_ff[k[1:0]] <= res;
         sjc_pkg::OP_ROT: rp_ff[k[1:0]] <= res;
         default: ;
      endcase
   end

   assign rsp_bone_slot = bone_ff;
   assign rsp_pos = rp_ff;
   assign rsp_rot = rq_ff;
   assign rsp_scl = rs_ff;
   assign rsp_fault = fault_ff;

`ifndef SYNTHESIS
   a_root_no_fault: assert property (@(posedge clock)
      sts.is_root |-> !sts.fault) else $error("root flagged");
   a_no_calc_root: assert property (@(posedge clock)
      (cmd.op != sjc_pkg::OP_NONE) |-> !(root_ff || fault_ff)) else $error("compose on root");
   a_load_excl: assert property (@(posedge clock)
      cmd.load |-> (cmd.op == sjc_pkg::OP_NONE && !cmd.wr_joint)) else $error("command clash");
`endif
endmodule

/* hw/rtl/skeletal_joint_composition.sv */
// top level of skeletal joint composition
// One bone word at a time: a root or faulty-parent bone goes from parent read to store
// and result; a child bone does parent read, then 22 steps of one shared round-and-
// saturate unit of up to four 32x32 products (3 scale, 4 quaternion, 9 matrix, 3 scaled
// vector, 3 rotated translation), then store and result. Ready comes back in the cycle
// after the result is taken. Parents must be sent before children; model-space joints
// are kept in a 256-slot single-port memory that is not cleared after reset.
module skeletal_joint_composition (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_bone_slot,
   input  logic [15:0]         req_parent_slot,
   input  logic signed [31:0]  req_local_pos_x, req_local_pos_y, req_local_pos_z,
   input  logic signed [31:0]  req_local_rot_x, req_local_rot_y, req_local_rot_z,
   input  logic signed [31:0]  req_local_rot_w,
   input  logic signed [31:0]  req_local_scl_x, req_local_scl_y, req_local_scl_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_bone_slot,
   output logic signed [31:0]  rsp_world_pos_x, rsp_world_pos_y, rsp_world_pos_z,
   output logic signed [31:0]  rsp_world_rot_x, rsp_world_rot_y, rsp_world_rot_z,
   output logic signed [31:0]  rsp_world_rot_w,
   output logic signed [31:0]  rsp_world_scl_x, rsp_world_scl_y, rsp_world_scl_z,
   output logic                rsp_parent_fault
);
   sjc_pkg::cmd_type cmd;
   sjc_pkg::sts_type sts;
   logic signed [31:0] p [3], q [4], s [3];

   sjc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd));

   sjc_datapath u_dp (
      .clock(clock), .cmd(cmd), .sts(sts),
      .req_bone_slot(req_bone_slot), .req_parent_slot(req_parent_slot),
      .req_pos('{req_local_pos_x, req_local_pos_y, req_local_pos_z}),
      .req_rot('{req_local_rot_x, req_local_rot_y, req_local_rot_z, req_local_rot_w}),
      .req_scl('{req_local_scl_x, req_local_scl_y, req_local_scl_z}),
      .rsp_bone_slot(rsp_out_bone_slot), .rsp_pos(p), .rsp_rot(q), .rsp_scl(s),
      .rsp_fault(rsp_parent_fault));

   assign rsp_world_pos_x = p[0];
   assign rsp_world_pos_y = p[1];
   assign rsp_world_pos_z = p[2];
   assign rsp_world_rot_x = q[0];
   assign rsp_world_rot_y = q[1];
   assign rsp_world_rot_z = q[2];
   assign rsp_world_rot_w = q[3];
   assign rsp_world_scl_x = s[0];
   assign rsp_world_scl_y = s[1];
   assign rsp_world_scl_z = s[2];
endmodule

/* test/skeletal_joint_composition_tb.sv */
// testbench for skeletal joint composition: random bone hierarchies checked against a predictor
`timescale 1ns / 100ps

module skeletal_joint_composition_tb;

   typedef struct {
      logic [7:0]         bone;
      logic [15:0]        parent;
      logic signed [31:0] p [3];
      logic signed [31:0] q [4];
      logic signed [31:0] s [3];
   } bone_word_t;

   typedef struct {
      logic [7:0]         bone;
      logic signed [31:0] p [3];
      logic signed [31:0] q [4];
      logic signed [31:0] s [3];
      logic               fault;
   } joint_word_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [7:0] req_bone_slot = '0;
   logic [15:0] req_parent_slot = '0;
   logic signed [31:0] req_local_pos_x = '0, req_local_pos_y = '0, req_local_pos_z = '0;
   logic signed [31:0] req_local_rot_x = '0, req_local_rot_y = '0, req_local_rot_z = '0;
   logic signed [31:0] req_local_rot_w = '0;
   logic signed [31:0] req_local_scl_x = '0, req_local_scl_y = '0, req_local_scl_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [7:0] rsp_out_bone_slot;
   logic signed [31:0] rsp_world_pos_x, rsp_world_pos_y, rsp_world_pos_z;
   logic signed [31:0] rsp_world_rot_x, rsp_world_rot_y, rsp_world_rot_z, rsp_world_rot_w;
   logic signed [31:0] rsp_world_scl_x, rsp_world_scl_y, rsp_world_scl_z;
   logic rsp_parent_fault;

   skeletal_joint_composition dut (.*);

   initial forever #10 clock = ~clock;

   bone_word_t  pending_bones [$];
   joint_word_t model_joints [$];
   joint_word_t model_space [sjc_pkg::MaxBones];
   bit          slot_written [sjc_pkg::MaxBones];
   int          fail_count = 0;
   bit          stim_done = 0;
   int          cyc = 0;

   function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
      if (x > 128'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -128'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // floor(x / 2^sh + 1/2)
   function automatic logic signed [127:0] half_up(input logic signed [127:0] x, input int sh);
      return (x + (128'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic joint_word_t compose_joint(input bone_word_t c);
      joint_word_t r, par;
      logic signed [127:0] x, y, z, w, cx, cy, cz, cw, one;
      logic signed [127:0] m [3][3];
      logic signed [127:0] sv [3];
      r.bone = c.bone;
      r.fault = 0;
      if (c.parent == sjc_pkg::RootMark || c.parent >= c.bone
          || c.parent >= sjc_pkg::MaxBones) begin
         r.fault = (c.parent != sjc_pkg::RootMark);
         r.p = c.p; r.q = c.q; r.s = c.s;
         return r;
      end
      par = model_space[c.parent[7:0]];
      x = par.q[0]; y = par.q[1]; z = par.q[2]; w = par.q[3];
      cx = c.q[0]; cy = c.q[1]; cz = c.q[2]; cw = c.q[3];
      one = 128'sd1 <<< 30;
      for (int i = 0; i < 3; i++)
         r.s[i] = clamp32(half_up(128'(par.s[i]) * 128'(c.s[i]), 16));
      r.q[0] = clamp32(half_up(w*cx + x*cw + y*cz - z*cy, 30));
      r.q[1] = clamp32(half_up(w*cy - x*cz + y*cw + z*cx, 30));
      r.q[2] = clamp32(half_up(w*cz + x*cy - y*cx + z*cw, 30));
      r.q[3] = clamp32(half_up(w*cw - x*cx - y*cy - z*cz, 30));
      m[0][0] = clamp32(one + half_up(-(y*y) - z*z, 29));
      m[0][1] = clamp32(half_up(x*y - w*z, 29));
      m[0][2] = clamp32(half_up(x*z + w*y, 29));
      m[1][0] = clamp32(half_up(x*y + w*z, 29));
      m[1][1] = clamp32(one + half_up(-(x*x) - z*z, 29));
      m[1][2] = clamp32(half_up(y*z - w*x, 29));
      m[2][0] = clamp32(half_up(x*z - w*y, 29));
      m[2][1] = clamp32(half_up(y*z + w*x, 29));
      m[2][2] = clamp32(one + half_up(-(x*x) - y*y, 29));
      for (int i = 0; i < 3; i++)
         sv[i] = clamp32(half_up(128'(c.p[i]) * 128'(par.s[i]), 16));
      for (int i = 0; i < 3; i++)
         r.p[i] = clamp32(half_up(m[i][0]*sv[0] + m[i][1]*sv[1] + m[i][2]*sv[2], 30)
                          + 128'(par.p[i]));
      return r;
   endfunction

   function automatic logic [31:0] rand_word(input int kind);
      case (kind)
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly sensible joints, some wild values
   function automatic bone_word_t make_bone(input logic [7:0] b, input logic [15:0] par);
      bone_word_t w;
      int wild;
      w.bone = b;
      w.parent = par;
      wild = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 3; i++) begin
         w.p[i] = wild ? rand_word($urandom_range(0, 7)) : $signed($urandom_range(0, 1 << 22))
                  - (1 << 21);
         w.s[i] = wild ? rand_word($urandom_range(0, 7)) : $signed($urandom_range(0, 1 << 18));
      end
      for (int i = 0; i < 4; i++)
         w.q[i] = wild ? rand_word($urandom_range(0, 7)) : $signed($urandom_range(0, 1 << 31))
                  - (1 << 30);
      return w;
   endfunction

   function automatic void add_bone(input bone_word_t w);
      joint_word_t r;
      r = compose_joint(w);
      if (w.bone < sjc_pkg::MaxBones) begin
         model_space[w.bone] = r;
         slot_written[w.bone] = 1;
      end
      model_joints.push_back(r);
      pending_bones.push_back(w);
   endfunction

   function automatic void add_extreme(input logic [7:0] b, input logic [15:0] par,
                                       input logic [31:0] v);
      bone_word_t w;
      w.bone = b; w.parent = par;
      for (int i = 0; i < 3; i++) begin w.p[i] = v; w.s[i] = v; end
      for (int i = 0; i < 4; i++) w.q[i] = v;
      add_bone(w);
   endfunction

   function automatic logic [15:0] pick_parent(input logic [7:0] b);
      int r, p;
      r = $urandom_range(0, 99);
      if (r < 10 || b == 0) return sjc_pkg::RootMark;
      if (r < 16) return 16'(b + $urandom_range(0, 65535 - b - 1)); // faulty
      // written earlier slot
      for (int k = 0; k < 8; k++) begin
         p = $urandom_range(0, b - 1);
         if (slot_written[p[7:0]]) return 16'(p);
      end
      return sjc_pkg::RootMark;
   endfunction

   initial begin
      logic [7:0] b;
      // predictor is evaluated when items are queued: order is kept end to end
      add_extreme(0, sjc_pkg::RootMark, 32'h40000000);
      add_extreme(1, 0, 32'h40000000);
      add_extreme(2, 1, 32'h7FFFFFFF);
      add_extreme(3, 2, 32'h80000000);
      add_extreme(4, 3, 32'h80000000);
      add_extreme(5, 0, 32'h0);
      add_extreme(6, 4, 32'hFFFFFFFF);
      add_extreme(255, sjc_pkg::RootMark, 32'h7FFFFFFF);
      add_extreme(254, 255, 32'h12345678);  // parent not earlier
      add_extreme(7, 7, 32'h1);             // own slot
      add_extreme(8, 16'hFFFE, 32'h2);
      add_extreme(9, 16'h0100, 32'h3);
      add_extreme(10, 9, 32'hDEADBEEF);
      add_extreme(200, 255, 32'h80000001);
      add_extreme(201, 200, 32'h7FFFFFFF);
      for (int n = 0; n < 1200; n++) begin
         b = (n % 10 == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
         add_bone(make_bone(b, pick_parent(b)));
      end
      stim_done = 1;
   end

   always @(posedge clock) cyc <= cyc + 1;

   function automatic bit busy_now(input int c);
      return (c % 1000) >= 200 && ($urandom_range(0, 99) < 25);
   endfunction

   // driver
   always @(posedge clock) begin
      bone_word_t w;
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (req_valid && req_ready) void'(pending_bones.pop_front());
            if (pending_bones.size() > 0 && !busy_now(cyc)) begin
               w = pending_bones[0];
               req_valid <= 1;
               req_bone_slot <= w.bone;
               req_parent_slot <= w.parent;
               req_local_pos_x <= w.p[0]; req_local_pos_y <= w.p[1];
               req_local_pos_z <= w.p[2];
               req_local_rot_x <= w.q[0]; req_local_rot_y <= w.q[1];
               req_local_rot_z <= w.q[2]; req_local_rot_w <= w.q[3];
               req_local_scl_x <= w.s[0]; req_local_scl_y <= w.s[1];
               req_local_scl_z <= w.s[2];
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h actual %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      joint_word_t e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (model_joints.size() == 0) begin
               $error("unexpected result word for bone %0d", rsp_out_bone_slot);
               fail_count++;
            end else begin
               e = model_joints.pop_front();
               check_field("out_bone_slot", e.bone, rsp_out_bone_slot);
               check_field("world_pos_x", e.p[0], rsp_world_pos_x);
               check_field("world_pos_y", e.p[1], rsp_world_pos_y);
               check_field("world_pos_z", e.p[2], rsp_world_pos_z);
               check_field("world_rot_x", e.q[0], rsp_world_rot_x);
               check_field("world_rot_y", e.q[1], rsp_world_rot_y);
               check_field("world_rot_z", e.q[2], rsp_world_rot_z);
               check_field("world_rot_w", e.q[3], rsp_world_rot_w);
               check_field("world_scl_x", e.s[0], rsp_world_scl_x);
               check_field("world_scl_y", e.s[1], rsp_world_scl_y);
               check_field("world_scl_z", e.s[2], rsp_world_scl_z);
               check_field("parent_fault", e.fault, rsp_parent_fault);
            end
         end
         rsp_ready <= !busy_now(cyc + 300);
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      wait (stim_done);
      while (pending_bones.size() > 0 || model_joints.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #10000000;
      $display("simulation failed");
      $finish;
   end

endmodule
